@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file lmsf_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define LMSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// clocked same-cycle implication, quiet while reset is asserted
`define LMSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/lmsf_pkg.sv @@
// constants and types of the line marker strip filter
// no dependencies
`timescale 1ns / 1ps

package lmsf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdW   = 64;
  localparam int unsigned LineW = 32;
  localparam int unsigned PctW  = 2;

  localparam logic [ByteW-1:0] PCT_BYTE     = 8'h25;
  localparam logic [ByteW-1:0] NL_BYTE      = 8'h0a;
  localparam logic [ByteW-1:0] DIGIT_LO     = 8'h30;
  localparam logic [ByteW-1:0] DIGIT_HI     = 8'h39;
  localparam logic [ByteW-1:0] BYTE_NONE    = 8'h00;
  localparam logic [LineW-1:0] FIRST_LINE_RST = 32'd1;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef enum logic [5:0] {
    MODE_LINE_START = 6'b000001,
    MODE_ONE_PCT    = 6'b000010,
    MODE_TWO_PCT    = 6'b000100,
    MODE_THREE_PCT  = 6'b001000,
    MODE_DIGITS     = 6'b010000,
    MODE_MID_LINE   = 6'b100000
  } scan_mode_e;

endpackage

@@ rtl/lmsf_in_if.sv @@
// input byte channel of the line marker strip filter
// depends on lmsf_pkg
`timescale 1ns / 1ps

interface lmsf_in_if;
  logic                       valid;
  logic                       ready;
  logic [lmsf_pkg::ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

@@ rtl/lmsf_out_if.sv @@
// result channel of the line marker strip filter
// depends on lmsf_pkg
`timescale 1ns / 1ps

interface lmsf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [lmsf_pkg::ByteW-1:0] byte_out;
  logic [lmsf_pkg::IdW-1:0]   marker_id;
  logic [lmsf_pkg::LineW-1:0] line_number;
  logic                       last;

  modport source (output valid, output kind, output byte_out, output marker_id,
                  output line_number, output last, input ready);
  modport sink   (input valid, input kind, input byte_out, input marker_id,
                  input line_number, input last, output ready);
endinterface

@@ rtl/line_marker_strip_filter.sv @@
// line marker strip filter top level
// depends on lmsf_pkg, lmsf_in_if, lmsf_out_if
//
//   channel  dir  payload                                     handshake
//   in_i     in   byte_in                                     valid/ready
//   out_o    out  kind byte_out marker_id line_number last    valid/ready
//   cfg      in   first_line (cfg_wdata_i)                    cfg_we_i
//
// one byte per cycle while in_i.ready is high: a byte is decoded in the cycle
// it is accepted; its results sit in the output register from the next cycle on.
// a byte that causes more than one result occupies the output register until
// its last result is taken, so a prefix replay or a marker record holds in_i.ready low.
// held bytes (prefix and digits) cause no result.
// out_o stalls propagate straight to in_i.ready through the output register.
// after reset the block is at line start with line number 1.
`timescale 1ns / 1ps

module line_marker_strip_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lmsf_in_if.sink                    in_i,
  lmsf_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [lmsf_pkg::LineW-1:0] cfg_wdata_i
);

  localparam int unsigned ProdW = lmsf_pkg::IdW + 4;

  lmsf_pkg::scan_mode_e mode_q, mode_d;
  logic                       busy_q, busy_d;
  logic [lmsf_pkg::PctW-1:0]  npct_q, npct_d;
  logic                       mark_q, mark_d;
  logic [lmsf_pkg::IdW-1:0]   acc_q, acc_d;
  logic [lmsf_pkg::LineW-1:0] line_q, line_d;
  logic [lmsf_pkg::ByteW-1:0] byte_q;
  logic [lmsf_pkg::LineW-1:0] mline_q;

  logic                       in_fire, out_fire, emit;
  logic                       is_pct, is_nl, is_digit;
  logic [3:0]                 digit;
  logic [ProdW-1:0]           prod;
  logic [lmsf_pkg::IdW-1:0]   acc_sat;
  logic                       out_marker, out_last;

  assign out_marker = (npct_q == '0) && mark_q;
  assign out_last   = (npct_q == '0) && !mark_q;

  assign in_i.ready = !busy_q || (out_o.ready && out_last);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  assign is_pct   = (in_i.byte_in == lmsf_pkg::PCT_BYTE);
  assign is_nl    = (in_i.byte_in == lmsf_pkg::NL_BYTE);
  assign is_digit = (in_i.byte_in >= lmsf_pkg::DIGIT_LO) &&
                    (in_i.byte_in <= lmsf_pkg::DIGIT_HI);
  assign digit    = in_i.byte_in[3:0];

  // acc * 10 + digit, saturating
  assign prod    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
                   ProdW'(digit);
  assign acc_sat = (prod[ProdW-1:lmsf_pkg::IdW] != '0) ? '1 :
                   prod[lmsf_pkg::IdW-1:0];

  always_comb begin
    mode_d = mode_q;
    busy_d = busy_q;
    npct_d = npct_q;
    mark_d = mark_q;
    acc_d  = acc_q;
    line_d = line_q;
    emit   = 1'b0;

    // drain the output register
    if (out_fire) begin
      if (npct_q != '0) begin
        npct_d = npct_q - 1'b1;
      end else if (mark_q) begin
        mark_d = 1'b0;
      end else begin
        busy_d = 1'b0;
      end
    end

    if (in_fire) begin
      emit   = 1'b1;
      npct_d = '0;
      mark_d = 1'b0;
      case (mode_q)
        lmsf_pkg::MODE_LINE_START: begin
          if (is_pct) begin
            mode_d = lmsf_pkg::MODE_ONE_PCT;
            emit   = 1'b0;
          end
        end
        lmsf_pkg::MODE_ONE_PCT: begin
          if (is_pct) begin
            mode_d = lmsf_pkg::MODE_TWO_PCT;
            emit   = 1'b0;
          end else begin
            npct_d = 2'd1;
          end
        end
        lmsf_pkg::MODE_TWO_PCT: begin
          if (is_pct) begin
            mode_d = lmsf_pkg::MODE_THREE_PCT;
            emit   = 1'b0;
          end else begin
            npct_d = 2'd2;
          end
        end
        lmsf_pkg::MODE_THREE_PCT: begin
          if (is_digit) begin
            mode_d = lmsf_pkg::MODE_DIGITS;
            acc_d  = lmsf_pkg::IdW'(digit);
            emit   = 1'b0;
          end else begin
            npct_d = 2'd3;
          end
        end
        lmsf_pkg::MODE_DIGITS: begin
          if (is_digit) begin
            acc_d = acc_sat;
            emit  = 1'b0;
          end else begin
            mark_d = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (emit) begin
        busy_d = 1'b1;
        if (is_nl) begin
          mode_d = lmsf_pkg::MODE_LINE_START;
          if (line_q != '1) begin
            line_d = line_q + 1'b1;
          end
        end else begin
          mode_d = lmsf_pkg::MODE_MID_LINE;
        end
      end else if (!out_fire) begin
        // held byte: pending results were already drained
        busy_d = busy_q;
      end
    end

    if (cfg_we_i) begin
      line_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lmsf_pkg::MODE_LINE_START;
      busy_q <= 1'b0;
      npct_q <= '0;
      mark_q <= 1'b0;
      acc_q  <= '0;
      line_q <= lmsf_pkg::FIRST_LINE_RST;
    end else begin
      mode_q <= mode_d;
      busy_q <= busy_d;
      npct_q <= npct_d;
      mark_q <= mark_d;
      acc_q  <= acc_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      byte_q  <= in_i.byte_in;
      mline_q <= line_q;
    end
  end

  assign out_o.valid       = busy_q;
  assign out_o.kind        = out_marker ? lmsf_pkg::KIND_MARKER : lmsf_pkg::KIND_BYTE;
  assign out_o.byte_out    = (npct_q != '0) ? lmsf_pkg::PCT_BYTE :
                             mark_q ? lmsf_pkg::BYTE_NONE : byte_q;
  assign out_o.marker_id   = out_marker ? acc_q : '0;
  assign out_o.line_number = out_marker ? mline_q : '0;
  assign out_o.last        = out_last;

endmodule

@@ rtl/lmsf_checker.sv @@
// port checker for the line marker strip filter, bound to the top level
// depends on lmsf_pkg, lmsf_in_if, lmsf_out_if, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmsf_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  lmsf_in_if.sink    in_i,
  lmsf_out_if.source out_o,
  input  logic       cfg_we_i
);

  logic beat_mark, beat_mid, mark_ok, mid_ok, out_stall;
  logic [lmsf_pkg::ByteW+lmsf_pkg::IdW+lmsf_pkg::LineW+1:0] beat_bits;

  assign beat_mark = out_o.valid && (out_o.kind == lmsf_pkg::KIND_MARKER);
  assign beat_mid  = out_o.valid && (out_o.kind == lmsf_pkg::KIND_BYTE) && !out_o.last;
  assign mark_ok   = !out_o.last && (out_o.byte_out == lmsf_pkg::BYTE_NONE);
  assign mid_ok    = (out_o.byte_out == lmsf_pkg::PCT_BYTE) && (out_o.marker_id == '0) &&
                     (out_o.line_number == '0);
  assign out_stall = out_o.valid && !out_o.ready && !cfg_we_i;
  assign beat_bits = {out_o.kind, out_o.byte_out, out_o.marker_id, out_o.line_number,
                      out_o.last};

  // a marker record is never the last beat of its byte and carries no text
  `LMSF_ASSERT_IMP(a_marker_shape, clk_i, rst_ni, beat_mark, mark_ok)

  // a text beat that is not last is a replayed percent sign
  `LMSF_ASSERT_IMP(a_replay_pct, clk_i, rst_ni, beat_mid, mid_ok)

  // input only backs up behind a waiting result
  `LMSF_ASSERT_IMP(a_in_stall, clk_i, rst_ni, !in_i.ready, out_o.valid && !(out_o.ready && out_o.last))

  // a stalled result beat holds (checked while cfg_we_i is low)
  `LMSF_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> (out_o.valid && $stable(beat_bits)))

endmodule

bind line_marker_strip_filter lmsf_checker u_lmsf_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .in_i    (in_i),
  .out_o   (out_o),
  .cfg_we_i(cfg_we_i)
);
